[design/binary_to_decimal_ascii_assert.svh]
// Assertion macros for the converter RTL.
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define B2DA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("b2da: implication check failed");

// Next-cycle implication, checked out of reset.
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("b2da: next-cycle check failed");

`endif

[design/b2da_pkg.sv]
package b2da_pkg;

    localparam int MAX_DIGITS = 20;
    localparam int VALUE_W    = 64;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 6;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int REMAIN_W   = $clog2(MAX_DIGITS + 1);

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  ASCII_NINE = CHAR_W'(57);
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = DIGIT_W'(3);

    // Control shared by every cell of the digit chain.
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // add-3 correction, then shift in one binary bit
        logic advance; // take the lower neighbor's digit
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

[design/b2da_cell.sv]
module b2da_cell (
    input  logic                          aclk,
    input  b2da_pkg::cell_ctrl_t          ctrl,
    input  logic                          carry_in,
    input  logic [b2da_pkg::DIGIT_W-1:0]  digit_in,
    output logic                          carry_out,
    output logic [b2da_pkg::DIGIT_W-1:0]  digit
);

    logic [b2da_pkg::DIGIT_W-1:0] digit_reg;
    logic [b2da_pkg::DIGIT_W-1:0] digit_next;
    logic [b2da_pkg::DIGIT_W-1:0] adj;

    // Correct digits of five or more so the shift carries into the next decade.
    assign adj = (digit_reg >= b2da_pkg::DABBLE_MIN) ? digit_reg + b2da_pkg::DABBLE_ADD
                                                      : digit_reg;
    assign carry_out = adj[b2da_pkg::DIGIT_W-1];
    assign digit     = digit_reg;

    always_comb begin
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.dabble) begin
            digit_next = {adj[b2da_pkg::DIGIT_W-2:0], carry_in};
        end else if (ctrl.advance) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

[design/b2da_chain.sv]
module b2da_chain (
    input  logic                          aclk,
    input  b2da_pkg::cell_ctrl_t          ctrl,
    input  logic                          bit_in,
    output logic [b2da_pkg::DIGIT_W-1:0]  top_digit
);

    logic                          carry [b2da_pkg::MAX_DIGITS];
    logic [b2da_pkg::DIGIT_W-1:0]  digit [b2da_pkg::MAX_DIGITS];

    // Cell 0 is the units decade; the top cell is the most significant.
    for (genvar i = 0; i < b2da_pkg::MAX_DIGITS; i++) begin : g_cell
        logic                          c_in;
        logic [b2da_pkg::DIGIT_W-1:0]  d_in;

        if (i == 0) begin : g_first
            assign c_in = bit_in;
            assign d_in = '0;
        end else begin : g_rest
            assign c_in = carry[i-1];
            assign d_in = digit[i-1];
        end

        b2da_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .carry_in  (c_in),
            .digit_in  (d_in),
            .carry_out (carry[i]),
            .digit     (digit[i])
        );
    end

    assign top_digit = digit[b2da_pkg::MAX_DIGITS-1];

endmodule

[design/binary_to_decimal_ascii.sv]
// Unsigned 64-bit binary to decimal ASCII converter. Each request on the s_
// channel carries one value; the m_ channel then delivers its decimal digits
// as ASCII characters '0'..'9', most significant first, without leading
// zeros, with m_last_digit marking the units digit. Zero gives the single
// character '0'. One value is in flight at a time: s_ready is high only
// while the converter is idle. A taken request is converted by double dabble,
// one input bit per cycle through a row of 20 BCD digit cells; leading zeros
// are then advanced past one digit at a time, and the digits are delivered
// one per cycle while m_ready is high. The output register lets the next
// request be taken while the final digit still waits on m_ready.
`include "binary_to_decimal_ascii_assert.svh"

module binary_to_decimal_ascii (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [b2da_pkg::VALUE_W-1:0]  s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [b2da_pkg::CHAR_W-1:0]   m_digit_char,
    output logic                          m_last_digit
);

    b2da_pkg::state_t              state_reg, state_next;
    logic [b2da_pkg::VALUE_W-1:0]  value_reg, value_next;
    logic [b2da_pkg::BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [b2da_pkg::REMAIN_W-1:0] remain_reg, remain_next;
    logic                          m_valid_reg, m_valid_next;
    logic [b2da_pkg::CHAR_W-1:0]   char_reg, char_next;
    logic                          last_reg, last_next;

    b2da_pkg::cell_ctrl_t          ctrl;
    logic [b2da_pkg::DIGIT_W-1:0]  top_digit;
    logic                          s_take;
    logic                          out_free;

    assign s_ready  = (state_reg == b2da_pkg::ST_IDLE);
    assign s_take   = s_valid && s_ready;
    // Output slot can take a new digit when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;

    b2da_chain u_chain (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .bit_in    (value_reg[b2da_pkg::VALUE_W-1]),
        .top_digit (top_digit)
    );

    always_comb begin
        state_next   = state_reg;
        value_next   = value_reg;
        bit_cnt_next = bit_cnt_reg;
        remain_next  = remain_reg;
        m_valid_next = m_valid_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        ctrl         = '0;

        // Drop the held digit once the consumer takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            b2da_pkg::ST_IDLE: begin
                // Latch the request and clear the digit chain.
                if (s_valid) begin
                    value_next   = s_value;
                    bit_cnt_next = '0;
                    ctrl.clear   = 1'b1;
                    state_next   = b2da_pkg::ST_CONV;
                end
            end
            b2da_pkg::ST_CONV: begin
                // Shift one binary bit, MSB first, into the units cell.
                ctrl.dabble  = 1'b1;
                value_next   = {value_reg[b2da_pkg::VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_W - 1)) begin
                    remain_next = b2da_pkg::REMAIN_W'(b2da_pkg::MAX_DIGITS);
                    state_next  = b2da_pkg::ST_SKIP;
                end
            end
            b2da_pkg::ST_SKIP: begin
                // Advance past leading zeros, keeping at least the units digit.
                if (top_digit == '0 && remain_reg > b2da_pkg::REMAIN_W'(1)) begin
                    ctrl.advance = 1'b1;
                    remain_next  = remain_reg - 1'b1;
                end else begin
                    state_next = b2da_pkg::ST_EMIT;
                end
            end
            b2da_pkg::ST_EMIT: begin
                // Hand the top digit to the output register, then advance.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    char_next    = b2da_pkg::ASCII_ZERO
                                   + {{(b2da_pkg::CHAR_W - b2da_pkg::DIGIT_W){1'b0}}, top_digit};
                    last_next    = (remain_reg == b2da_pkg::REMAIN_W'(1));
                    ctrl.advance = 1'b1;
                    remain_next  = remain_reg - 1'b1;
                    if (remain_reg == b2da_pkg::REMAIN_W'(1)) begin
                        state_next = b2da_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = b2da_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= b2da_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        value_reg   <= value_next;
        bit_cnt_reg <= bit_cnt_next;
        remain_reg  <= remain_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_digit_char = char_reg;
    assign m_last_digit = last_reg;

    // Every delivered character is a decimal digit.
    `B2DA_ASSERT_IMPLY(a_char_range, aclk, aresetn, m_valid_reg, (char_reg >= b2da_pkg::ASCII_ZERO) && (char_reg <= b2da_pkg::ASCII_NINE))
    // A taken request starts conversion at the first bit.
    `B2DA_ASSERT_NEXT(a_take_starts, aclk, aresetn, s_take, (state_reg == b2da_pkg::ST_CONV) && (bit_cnt_reg == '0))
    // Digit count never runs out before the units digit goes out.
    `B2DA_ASSERT_IMPLY(a_remain_live, aclk, aresetn, (state_reg == b2da_pkg::ST_EMIT) || (state_reg == b2da_pkg::ST_SKIP), remain_reg != '0)
    // Conversion always hands over to the leading-zero pass with a full count.
    `B2DA_ASSERT_NEXT(a_conv_done, aclk, aresetn, (state_reg == b2da_pkg::ST_CONV) && (bit_cnt_reg == b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_W - 1)), (state_reg == b2da_pkg::ST_SKIP) && (remain_reg == b2da_pkg::REMAIN_W'(b2da_pkg::MAX_DIGITS)))

endmodule
